// File: rtl/core/tcte_pkg.sv
// Shared types and constants for the tray cell table engine.
// Used by the controller, the datapath and the top level.
package tcte_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LOAD_W = CNT_W + 1;
  localparam int unsigned CELL_W = 17;
  localparam logic [7:0] VERDICT_INVALID = 8'd44;
  localparam logic [2:0] TRAY_ALL = 3'h7;
  localparam logic [1:0] VERDICT_NONE = 2'd3;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_FIND     = 3'd2,
    CMD_HAS      = 3'd3,
    CMD_UNIFORM  = 3'd4,
    CMD_TRANSFER = 3'd5,
    CMD_READ     = 3'd6,
    CMD_GEOM     = 3'd7
  } cmd_e;

  typedef struct packed {
    logic       geom;
    logic [7:0] cls;
    logic [7:0] tray;
  } cell_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic scan_init;
    logic scan_step;
    logic rd_src;
    logic rd_dst;
    logic wr_src;
    logic wr_dst;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic go_scan;
    logic rng_ok;
    logic scan_more;
    logic rd_pend;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/core/tcte_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tcte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tcte_ctrl.sv
// Command sequencer of the tray cell table engine.
// Depends on tcte_pkg; drives the datapath through ctrl_t, reads status_t.
module tcte_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tcte_pkg::status_t st_i,
  output tcte_pkg::ctrl_t   ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_T_SRC, S_T_RD, S_T_DST, S_WAIT, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    ctrl_o  = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        ctrl_o.decode = 1'b1;
        case (st_i.cmd)
          tcte_pkg::CMD_CLEAR: state_d = S_FIN;
          tcte_pkg::CMD_LOAD: begin
            if (st_i.go_scan) begin
              ctrl_o.scan_init = 1'b1;
              state_d = S_SCAN;
            end else begin
              state_d = S_FIN;
            end
          end
          tcte_pkg::CMD_TRANSFER: begin
            if (st_i.rng_ok) begin
              ctrl_o.rd_src = 1'b1;
              state_d = S_T_SRC;
            end else begin
              state_d = S_FIN;
            end
          end
          tcte_pkg::CMD_READ: begin
            if (st_i.rng_ok) begin
              ctrl_o.rd_src = 1'b1;
              state_d = S_WAIT;
            end else begin
              state_d = S_FIN;
            end
          end
          default: begin
            ctrl_o.scan_init = 1'b1;
            state_d = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (!st_i.scan_more && !st_i.rd_pend) begin
          state_d = S_FIN;
        end
      end
      S_T_SRC: begin
        ctrl_o.wr_src = 1'b1;
        state_d = S_T_RD;
      end
      S_T_RD: begin
        ctrl_o.rd_dst = 1'b1;
        state_d = S_T_DST;
      end
      S_T_DST: begin
        ctrl_o.wr_dst = 1'b1;
        state_d = S_FIN;
      end
      S_WAIT: state_d = S_FIN;
      S_FIN: begin
        if (!st_i.out_busy) begin
          ctrl_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/tcte_dp.sv
// Datapath of the tray cell table engine: cell RAM, counters, scan logic, result register.
// Depends on tcte_pkg and tcte_ram; steered by tcte_ctrl.
module tcte_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tcte_pkg::ctrl_t   ctrl_i,
  output tcte_pkg::status_t st_o,
  input  logic [2:0]        cmd_i,
  input  logic [61:0]       item_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [41:0]       out_o
);

  localparam int unsigned AW = tcte_pkg::ADDR_W;
  localparam int unsigned CW = tcte_pkg::CNT_W;
  localparam int unsigned LW = tcte_pkg::LOAD_W;

  // captured item
  tcte_pkg::cmd_e cmd_q;
  logic [61:0]    item_q;
  logic           last_q;

  logic [7:0]  tray;
  logic [7:0]  cls;
  logic        geom;
  logic        need_geom;
  logic [9:0]  declared;
  logic [7:0]  cols;
  logic [7:0]  rows;
  logic [8:0]  src;
  logic [8:0]  dst;

  assign tray      = item_q[7:0];
  assign cls       = item_q[15:8];
  assign geom      = item_q[16];
  assign need_geom = item_q[17];
  assign declared  = item_q[27:18];
  assign cols      = item_q[35:28];
  assign rows      = item_q[43:36];
  assign src       = item_q[52:44];
  assign dst       = item_q[61:53];

  // table state
  logic [CW-1:0] used_q;
  logic [LW-1:0] load_q;
  logic [2:0]    pres_q;
  logic          ok_q;

  // scan state
  logic [CW-1:0] scan_q;
  logic          pend_q;
  logic [AW-1:0] pidx_q;
  logic          found_q;
  logic [AW-1:0] fidx_q;
  logic [2:0]    seen_q;
  logic          bad_q;
  logic          gbad_q;
  logic [CW-1:0] n_q;
  logic [7:0]    cls_hold_q;

  // output register
  logic        out_valid_q;
  logic [41:0] out_q;

  // RAM
  logic              we;
  logic [AW-1:0]     waddr;
  tcte_pkg::cell_t   wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  tcte_pkg::cell_t   rdata;

  // load arithmetic
  logic [LW-1:0] load_nx;
  logic          load_fits;
  logic          load_good;
  logic [15:0]   slots;
  logic          scan_more;
  logic          hit;
  logic          args_bad;
  logic [1:0]    verdict;
  logic          res_ok;
  logic [8:0]    res_found;

  assign load_fits = (load_q < LW'(tcte_pkg::MAX_ENTRIES));
  assign load_nx   = (load_q <= LW'(tcte_pkg::MAX_ENTRIES)) ? load_q + LW'(1) : load_q;
  assign load_good = last_q && (load_nx == LW'(declared))
                     && (load_nx <= LW'(tcte_pkg::MAX_ENTRIES));
  assign scan_more = (scan_q < used_q);
  assign slots     = 16'(cols) * 16'(rows);
  assign args_bad  = (cols == 8'd0) || (rows == 8'd0) || (tray == 8'd0);

  assign st_o.cmd       = cmd_q;
  assign st_o.go_scan   = load_good;
  assign st_o.rng_ok    = (cmd_q == tcte_pkg::CMD_TRANSFER)
                          ? ((CW'(src) < used_q) && (CW'(dst) < used_q))
                          : (CW'(src) < used_q);
  assign st_o.scan_more = scan_more;
  assign st_o.rd_pend   = pend_q;
  assign st_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    we    = 1'b0;
    waddr = load_q[AW-1:0];
    wdata = '{geom: geom, cls: cls, tray: tray};
    re    = 1'b0;
    raddr = scan_q[AW-1:0];
    if (ctrl_i.decode && (cmd_q == tcte_pkg::CMD_LOAD) && load_fits) begin
      we = 1'b1;
    end
    if (ctrl_i.wr_src) begin
      we    = 1'b1;
      waddr = src[AW-1:0];
      wdata = '{geom: rdata.geom, cls: 8'd0, tray: rdata.tray};
    end
    if (ctrl_i.wr_dst) begin
      we    = 1'b1;
      waddr = dst[AW-1:0];
      wdata = '{geom: rdata.geom, cls: cls_hold_q, tray: rdata.tray};
    end
    if (ctrl_i.rd_src) begin
      re    = 1'b1;
      raddr = src[AW-1:0];
    end
    if (ctrl_i.rd_dst) begin
      re    = 1'b1;
      raddr = dst[AW-1:0];
    end
    if (ctrl_i.scan_step && scan_more) begin
      re = 1'b1;
    end
  end

  tcte_ram #(
    .WIDTH (tcte_pkg::CELL_W),
    .DEPTH (tcte_pkg::MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign hit = (rdata.tray == tray) && (rdata.cls == cls)
               && (!(need_geom && (cmd_q == tcte_pkg::CMD_FIND)) || rdata.geom);

  always_comb begin
    verdict = tcte_pkg::VERDICT_NONE;
    if (!args_bad && !bad_q && (16'(n_q) == slots)) begin
      case (seen_q)
        3'b001:  verdict = 2'd0;
        3'b010:  verdict = 2'd1;
        3'b100:  verdict = 2'd2;
        default: verdict = tcte_pkg::VERDICT_NONE;
      endcase
    end
  end

  always_comb begin
    res_ok    = 1'b0;
    res_found = '0;
    case (cmd_q)
      tcte_pkg::CMD_CLEAR:    res_ok = 1'b1;
      tcte_pkg::CMD_LOAD:     res_ok = ok_q;
      tcte_pkg::CMD_FIND,
      tcte_pkg::CMD_HAS: begin
        res_ok    = found_q;
        res_found = found_q ? 9'(fidx_q) : 9'd0;
      end
      tcte_pkg::CMD_UNIFORM:  res_ok = (verdict != tcte_pkg::VERDICT_NONE);
      tcte_pkg::CMD_TRANSFER: res_ok = ok_q;
      tcte_pkg::CMD_READ:     res_ok = ok_q;
      default:                res_ok = (used_q != '0) && !gbad_q;
    endcase
  end

  // item capture and per-command bookkeeping
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= tcte_pkg::cmd_e'(cmd_i);
      item_q <= item_i;
      last_q <= last_i;
    end
    if (ctrl_i.wr_src) begin
      cls_hold_q <= rdata.cls;
    end
    if (ctrl_i.finish) begin
      out_q[0]     <= res_ok;
      out_q[9:1]   <= res_found;
      out_q[11:10] <= (cmd_q == tcte_pkg::CMD_UNIFORM) ? verdict : tcte_pkg::VERDICT_NONE;
      out_q[14:12] <= pres_q & tcte_pkg::TRAY_ALL;
      out_q[15]    <= ((pres_q & tcte_pkg::TRAY_ALL) == tcte_pkg::TRAY_ALL);
      out_q[24:16] <= 9'(used_q);
      if ((cmd_q == tcte_pkg::CMD_READ) && ok_q) begin
        out_q[32:25] <= rdata.tray;
        out_q[40:33] <= rdata.cls;
        out_q[41]    <= rdata.geom;
      end else begin
        out_q[41:25] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      load_q      <= '0;
      pres_q      <= '0;
      ok_q        <= 1'b0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      found_q     <= 1'b0;
      fidx_q      <= '0;
      seen_q      <= '0;
      bad_q       <= 1'b0;
      gbad_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.decode) begin
        case (cmd_q)
          tcte_pkg::CMD_CLEAR: begin
            used_q <= '0;
            load_q <= '0;
            pres_q <= '0;
          end
          tcte_pkg::CMD_LOAD: begin
            if (!last_q) begin
              // the first row of a load empties the table
              if (load_q == '0) begin
                used_q <= '0;
                pres_q <= '0;
              end
              load_q <= load_nx;
              ok_q   <= 1'b1;
            end else begin
              // close the load: adopt the rows, or drop the whole table
              load_q <= '0;
              pres_q <= '0;
              used_q <= load_good ? load_nx[CW-1:0] : '0;
              ok_q   <= load_good;
            end
          end
          default: ok_q <= st_o.rng_ok;
        endcase
      end
      if (ctrl_i.scan_init) begin
        scan_q  <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
        fidx_q  <= '0;
        seen_q  <= '0;
        bad_q   <= 1'b0;
        gbad_q  <= 1'b0;
        n_q     <= '0;
      end else if (ctrl_i.scan_step) begin
        pend_q <= scan_more;
        pidx_q <= scan_q[AW-1:0];
        if (scan_more) begin
          scan_q <= scan_q + CW'(1);
        end
        if (pend_q) begin
          if (hit && !found_q) begin
            found_q <= 1'b1;
            fidx_q  <= pidx_q;
          end
          if (rdata.tray == tray) begin
            n_q <= n_q + CW'(1);
            case (rdata.cls)
              8'd0:    seen_q[0] <= 1'b1;
              8'd1:    seen_q[1] <= 1'b1;
              8'd2:    seen_q[2] <= 1'b1;
              default: bad_q     <= 1'b1;
            endcase
          end
          if (!rdata.geom) begin
            gbad_q <= 1'b1;
          end
          if (cmd_q == tcte_pkg::CMD_LOAD) begin
            case (rdata.tray)
              8'd1:    pres_q[0] <= 1'b1;
              8'd2:    pres_q[1] <= 1'b1;
              8'd3:    pres_q[2] <= 1'b1;
              default: pres_q    <= pres_q;
            endcase
          end
        end
      end
      if (ctrl_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/tray_cell_table_engine.sv
// Top level of the tray cell table engine: stream ports around controller and datapath.
// Depends on tcte_pkg, tcte_ctrl, tcte_dp (and tcte_ram through the datapath).
//
// Usage:
//   One command enters on the slave stream (s_axis_*) as one item; exactly one
//   result item leaves on the master stream (m_axis_*). tuser carries the
//   command code, tlast the last-row marker of a table load.
//   Items are taken one at a time: s_axis_tready is high only while no
//   command is in progress. A result that waits in the output register does
//   not block the next item; only the finish of that next command waits.
//   Clear, rows that are not last, failed loads and out-of-range transfer
//   or read go from decode to finish; read waits for its RAM read; transfer
//   reads and writes the source, then the destination; find first, has class,
//   uniform check, all geometry valid and a successful last row scan the
//   table through the one RAM read port, one entry per cycle.
//   Reset clears the counters and the tray mask; the cell RAM is not cleared,
//   since only entries written since the last load are ever read.
//   When the receiver stalls, the result holds on m_axis_tdata.
module tray_cell_table_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: tray_id[7:0], class_label[15:8], geom_ok[16], need_geom[17],
  // row_total[27:18], tray_cols[35:28], tray_rows[43:36], src_index[52:44],
  // dst_index[61:53], zero fill [63:62]
  input  logic [63:0] s_axis_tdata,
  // tuser: command[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: ok[0], found_index[9:1], verdict[11:10], tray_mask[14:12],
  // all_three[15], entry_count[24:16], read_tray[32:25], read_class[40:33],
  // read_geom[41], zero fill [47:42]
  output logic [47:0] m_axis_tdata
);

  tcte_pkg::ctrl_t   ctrl;
  tcte_pkg::status_t status;
  logic [41:0]       result;

  // sequence each command: capture, decode, scan or RAM steps, finish
  tcte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (status),
    .ctrl_o     (ctrl)
  );

  // hold the table, the counters and the result register
  tcte_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .st_o        (status),
    .cmd_i       (s_axis_tuser),
    .item_i      (s_axis_tdata[61:0]),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (result)
  );

  assign m_axis_tdata = {6'd0, result};

endmodule
